@@ hw/rtl/rational_arith_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rational_arith_unit: assertion failed");

// next-cycle implication
`define RAU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rational_arith_unit: assertion failed");

`endif

@@ hw/rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int QDEPTH    = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4,
    OP_RED = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NGCD,
    ST_NDIVN,
    ST_NDIVD,
    ST_DISP,
    ST_AGCD,
    ST_AM1,
    ST_AM2,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_RGCD,
    ST_RDIVN,
    ST_RDIVD,
    ST_DONE
  } st_e;

  // classification of one request, made by the front end
  typedef struct packed {
    op_e  op;
    logic err;
    logic ln_neg;
    logic rn_neg;
  } cls_t;

endpackage

@@ hw/rtl/rau_front.sv @@
// ----------------------------------------------------------------------------
// rau_front
// Splits operands into sign and magnitude and flags error requests.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int W = 16
) (
  input  logic [2:0]   opcode_i,
  input  logic [W-1:0] lhs_num_i,
  input  logic [W-1:0] lhs_den_i,
  input  logic [W-1:0] rhs_num_i,
  input  logic [W-2:0] rhs_den_i,
  output rau_pkg::cls_t cls_o,
  output logic [W-1:0] ln_o,
  output logic [W-1:0] ld_o,
  output logic [W-1:0] rn_o,
  output logic [W-1:0] rd_o
);
  import rau_pkg::*;

  logic ln_s, ld_s, rn_s;
  logic bad_op, rhs_bad;

  assign ln_s = lhs_num_i[W-1];
  assign ld_s = lhs_den_i[W-1];
  assign rn_s = rhs_num_i[W-1];

  assign ln_o = ln_s ? (~lhs_num_i + 1'b1) : lhs_num_i;
  assign ld_o = ld_s ? (~lhs_den_i + 1'b1) : lhs_den_i;
  assign rn_o = rn_s ? (~rhs_num_i + 1'b1) : rhs_num_i;
  assign rd_o = {1'b0, rhs_den_i};

  assign bad_op  = opcode_i > OP_RED;
  assign rhs_bad = (opcode_i != OP_RED) &&
                   ((rd_o == '0) || ((opcode_i == OP_DIV) && (rn_o == '0)));

  always_comb begin
    cls_o.op     = op_e'(opcode_i);
    cls_o.err    = bad_op || (ld_o == '0) || rhs_bad;
    // sign moves to the numerator; zero carries no sign
    cls_o.ln_neg = (ln_s ^ ld_s) && (ln_o != '0);
    cls_o.rn_neg = rn_s;
  end

endmodule

@@ hw/rtl/rau_queue.sv @@
// ----------------------------------------------------------------------------
// rau_queue
// Short request queue between front end and execution back end.
// ----------------------------------------------------------------------------
module rau_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic [DW-1:0] rdata_o,
  output logic          avail_o
);
  import rau_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [DW-1:0] mem_q [QDEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign full_o  = cnt_q == CW'(QDEPTH);
  assign avail_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && avail_o;

  always_comb begin
    wp_d  = do_wr ? ((wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1) : wp_q;
    rp_d  = do_rd ? ((rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1) : rp_q;
    cnt_d = cnt_q + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/rau_back.sv @@
// ----------------------------------------------------------------------------
// rau_back
// Sequencer with one multiplier and a shared iterative gcd / divide unit.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int W = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           avail_i,
  output logic                           take_o,
  input  rau_pkg::cls_t                  cls_i,
  input  logic [W-1:0]                   ln_i,
  input  logic [W-1:0]                   ld_i,
  input  logic [W-1:0]                   rn_i,
  input  logic [W-1:0]                   rd_i,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [rau_pkg::RES_NUM_W-1:0]  res_num_o,
  output logic [rau_pkg::RES_DEN_W-1:0]  res_den_o,
  output logic                           is_equal_o,
  output logic                           status_o
);
  import rau_pkg::*;

  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW + 1);
  localparam int NW = (MW + 1 > RES_NUM_W) ? MW + 1 : RES_NUM_W;
  localparam int DW = (MW > RES_DEN_W) ? MW : RES_DEN_W;

  st_e           st_q, st_d;
  op_e           op_q, op_d;
  logic          lnn_q, lnn_d, rnn_q, rnn_d, neg_q, neg_d;
  logic          eq_q, eq_d, err_q, err_d;
  logic [W-1:0]  ln_q, ln_d, ld_q, ld_d, rn_q, rn_d, rd_q, rd_d;
  logic [W-1:0]  t_q, t_d, m1_q, m1_d, m2_q, m2_d;
  logic [MW-1:0] pa_q, pa_d, pb_q, pb_d, mag_q, mag_d, den_q, den_d;

  // iterative unit
  logic          run_q, run_d;
  logic [MW-1:0] ga_q, ga_d, gb_q, gb_d, quo_q, quo_d, dv_q, dv_d;
  logic [KW-1:0] gk_q, gk_d, dc_q, dc_d;
  logic [MW:0]   rem_q, rem_d;

  logic          gcd_sel, div_sel;
  logic [MW-1:0] g_a, g_b, d_n, d_v;
  logic          gcd_done, div_done;
  logic [MW-1:0] gcd_res;
  logic [MW-1:0] ga_n, gb_n;
  logic [KW-1:0] gk_n;
  logic [MW:0]   sh, rem_n;
  logic          ge;

  // multiplier
  logic [W-1:0]  mul_a, mul_b;
  logic [MW-1:0] prod;

  // output register
  logic                 ov_q, ov_d;
  logic [RES_NUM_W-1:0] onum_q, onum_d;
  logic [RES_DEN_W-1:0] oden_q, oden_d;
  logic                 oeq_q, oeq_d, ost_q, ost_d;
  logic [NW-1:0]        nwide;
  logic [DW-1:0]        dwide;
  logic                 bneg;

  assign prod = mul_a * mul_b;

  // binary gcd step
  assign gcd_done = (ga_q == '0) || (gb_q == '0);
  assign gcd_res  = (ga_q | gb_q) << gk_q;
  always_comb begin
    ga_n = ga_q;
    gb_n = gb_q;
    gk_n = gk_q;
    if (!ga_q[0] && !gb_q[0]) begin
      ga_n = ga_q >> 1;
      gb_n = gb_q >> 1;
      gk_n = gk_q + 1'b1;
    end else if (!ga_q[0]) begin
      ga_n = ga_q >> 1;
    end else if (!gb_q[0]) begin
      gb_n = gb_q >> 1;
    end else if (ga_q >= gb_q) begin
      ga_n = ga_q - gb_q;
    end else begin
      gb_n = gb_q - ga_q;
    end
  end

  // restoring divide step, quotient shifts into the dividend register
  assign div_done = dc_q == '0;
  assign sh       = {rem_q[MW-1:0], quo_q[MW-1]};
  assign ge       = sh >= {1'b0, dv_q};
  assign rem_n    = ge ? (sh - {1'b0, dv_q}) : sh;

  always_comb begin
    st_d  = st_q;   op_d  = op_q;   lnn_d = lnn_q;  rnn_d = rnn_q;
    neg_d = neg_q;  eq_d  = eq_q;   err_d = err_q;
    ln_d  = ln_q;   ld_d  = ld_q;   rn_d  = rn_q;   rd_d  = rd_q;
    t_d   = t_q;    m1_d  = m1_q;   m2_d  = m2_q;
    pa_d  = pa_q;   pb_d  = pb_q;   mag_d = mag_q;  den_d = den_q;
    run_d = run_q;  ga_d  = ga_q;   gb_d  = gb_q;   gk_d  = gk_q;
    quo_d = quo_q;  dv_d  = dv_q;   dc_d  = dc_q;   rem_d = rem_q;
    ov_d  = ov_q && !pop_i;
    onum_d = onum_q; oden_d = oden_q; oeq_d = oeq_q; ost_d = ost_q;
    take_o  = 1'b0;
    gcd_sel = 1'b0;
    div_sel = 1'b0;
    g_a = '0;  g_b = '0;  d_n = '0;  d_v = '0;
    mul_a = '0;
    mul_b = '0;
    bneg  = (op_q == OP_SUB) ? !rnn_q : rnn_q;
    nwide = NW'(mag_q);
    if (neg_q && (mag_q != '0)) begin
      nwide = ~nwide + 1'b1;
    end
    dwide = DW'(den_q);

    case (st_q)
      ST_IDLE: begin
        if (avail_i) begin
          take_o = 1'b1;
          op_d  = cls_i.op;
          lnn_d = cls_i.ln_neg;
          rnn_d = cls_i.rn_neg;
          err_d = cls_i.err;
          eq_d  = 1'b0;
          ln_d  = ln_i;  ld_d = ld_i;  rn_d = rn_i;  rd_d = rd_i;
          mag_d = '0;
          den_d = MW'(1);
          neg_d = 1'b0;
          st_d  = cls_i.err ? ST_DONE : ST_NGCD;
        end
      end
      ST_NGCD: begin
        gcd_sel = 1'b1;
        g_a = MW'(ln_q);
        g_b = MW'(ld_q);
        if (run_q && gcd_done) begin
          t_d  = gcd_res[W-1:0];
          st_d = ST_NDIVN;
        end
      end
      ST_NDIVN: begin
        div_sel = 1'b1;
        d_n = MW'(ln_q);
        d_v = MW'(t_q);
        if (run_q && div_done) begin
          ln_d = quo_q[W-1:0];
          st_d = ST_NDIVD;
        end
      end
      ST_NDIVD: begin
        div_sel = 1'b1;
        d_n = MW'(ld_q);
        d_v = MW'(t_q);
        if (run_q && div_done) begin
          ld_d = quo_q[W-1:0];
          st_d = ST_DISP;
        end
      end
      ST_DISP: begin
        case (op_q)
          OP_RED: begin
            mag_d = MW'(ln_q);
            den_d = (ln_q == '0) ? MW'(1) : MW'(ld_q);
            neg_d = lnn_q;
            st_d  = ST_DONE;
          end
          OP_ADD, OP_SUB: st_d = ST_AGCD;
          default:        st_d = ST_MUL1;
        endcase
      end
      ST_AGCD: begin
        gcd_sel = 1'b1;
        g_a = MW'(ld_q);
        g_b = MW'(rd_q);
        if (run_q && gcd_done) begin
          t_d  = gcd_res[W-1:0];
          st_d = ST_AM1;
        end
      end
      ST_AM1: begin
        div_sel = 1'b1;
        d_n = MW'(rd_q);
        d_v = MW'(t_q);
        if (run_q && div_done) begin
          m1_d = quo_q[W-1:0];
          st_d = ST_AM2;
        end
      end
      ST_AM2: begin
        div_sel = 1'b1;
        d_n = MW'(ld_q);
        d_v = MW'(t_q);
        if (run_q && div_done) begin
          m2_d = quo_q[W-1:0];
          st_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        mul_a = ln_q;
        case (op_q)
          OP_ADD, OP_SUB: mul_b = m1_q;
          OP_MUL:         mul_b = rn_q;
          default:        mul_b = rd_q;
        endcase
        pa_d = prod;
        st_d = ST_MUL2;
      end
      ST_MUL2: begin
        case (op_q)
          OP_ADD, OP_SUB: begin mul_a = rn_q; mul_b = m2_q; end
          OP_MUL:         begin mul_a = ld_q; mul_b = rd_q; end
          default:        begin mul_a = ld_q; mul_b = rn_q; end
        endcase
        case (op_q)
          OP_ADD, OP_SUB: begin
            pb_d = prod;
            st_d = ST_MUL3;
          end
          OP_CMP: begin
            eq_d = (lnn_q == rnn_q) && (pa_q == prod);
            st_d = ST_DONE;
          end
          default: begin
            mag_d = pa_q;
            den_d = prod;
            neg_d = lnn_q ^ rnn_q;
            st_d  = ST_RGCD;
          end
        endcase
      end
      ST_MUL3: begin
        mul_a = ld_q;
        mul_b = m1_q;
        den_d = prod;
        st_d  = ST_COMB;
      end
      ST_COMB: begin
        if (lnn_q == bneg) begin
          mag_d = pa_q + pb_q;
          neg_d = lnn_q;
        end else if (pa_q >= pb_q) begin
          mag_d = pa_q - pb_q;
          neg_d = lnn_q;
        end else begin
          mag_d = pb_q - pa_q;
          neg_d = bneg;
        end
        st_d = ST_RGCD;
      end
      ST_RGCD: begin
        gcd_sel = 1'b1;
        g_a = mag_q;
        g_b = den_q;
        if (run_q && gcd_done) begin
          pb_d = gcd_res;
          st_d = ST_RDIVN;
        end
      end
      ST_RDIVN: begin
        div_sel = 1'b1;
        d_n = mag_q;
        d_v = pb_q;
        if (run_q && div_done) begin
          mag_d = quo_q;
          st_d  = ST_RDIVD;
        end
      end
      ST_RDIVD: begin
        div_sel = 1'b1;
        d_n = den_q;
        d_v = pb_q;
        if (run_q && div_done) begin
          den_d = quo_q;
          st_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || pop_i) begin
          ov_d   = 1'b1;
          onum_d = nwide[RES_NUM_W-1:0];
          oden_d = dwide[RES_DEN_W-1:0];
          oeq_d  = eq_q;
          ost_d  = err_q;
          st_d   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // shared unit: load on entry, step until done, release on capture
    if (gcd_sel) begin
      if (!run_q) begin
        ga_d  = g_a;
        gb_d  = g_b;
        gk_d  = '0;
        run_d = 1'b1;
      end else if (!gcd_done) begin
        ga_d = ga_n;
        gb_d = gb_n;
        gk_d = gk_n;
      end else begin
        run_d = 1'b0;
      end
    end else if (div_sel) begin
      if (!run_q) begin
        quo_d = d_n;
        dv_d  = d_v;
        rem_d = '0;
        dc_d  = KW'(MW);
        run_d = 1'b1;
      end else if (!div_done) begin
        rem_d = rem_n;
        quo_d = {quo_q[MW-2:0], ge};
        dc_d  = dc_q - 1'b1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      run_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      run_q <= run_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_reg: begin end
    op_q  <= op_d;   lnn_q <= lnn_d;  rnn_q <= rnn_d;  neg_q <= neg_d;
    eq_q  <= eq_d;   err_q <= err_d;
    ln_q  <= ln_d;   ld_q  <= ld_d;   rn_q  <= rn_d;   rd_q  <= rd_d;
    t_q   <= t_d;    m1_q  <= m1_d;   m2_q  <= m2_d;
    pa_q  <= pa_d;   pb_q  <= pb_d;   mag_q <= mag_d;  den_q <= den_d;
    ga_q  <= ga_d;   gb_q  <= gb_d;   gk_q  <= gk_d;
    quo_q <= quo_d;  dv_q  <= dv_d;   dc_q  <= dc_d;   rem_q <= rem_d;
    onum_q <= onum_d; oden_q <= oden_d; oeq_q <= oeq_d; ost_q <= ost_d;
  end

  assign empty_o    = !ov_q;
  assign res_num_o  = onum_q;
  assign res_den_o  = oden_q;
  assign is_equal_o = oeq_q;
  assign status_o   = ost_q;

endmodule

@@ hw/rtl/rational_arith_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact rational add/sub/mul/div/compare/reduce with gcd-reduced results.
//
//   channel   handshake          payload
//   request   push_i / full_o    opcode, lhs_num, lhs_den, rhs_num, rhs_den
//   result    pop_i  / empty_o   res_num, res_den, is_equal, status
//
// One request is executed at a time; a two-entry queue takes requests
// while the back end works, and a result register lets it start the next
// one while the previous result waits. A valid request runs two to six
// divides and one to three binary gcd runs on the shared iterative unit;
// error requests skip both and go straight to the result. No clearing
// pass after reset.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic [2:0]                            opcode_i,
  input  logic signed [OPERAND_WIDTH-1:0]       lhs_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]       lhs_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]       rhs_num_i,
  input  logic [OPERAND_WIDTH-2:0]              rhs_den_i,
  input  logic                                  pop_i,
  output logic                                  empty_o,
  output logic signed [rau_pkg::RES_NUM_W-1:0]  res_num_o,
  output logic [rau_pkg::RES_DEN_W-1:0]         res_den_o,
  output logic                                  is_equal_o,
  output logic                                  status_o
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int QW = $bits(cls_t) + 4 * W;

  cls_t          f_cls, b_cls;
  logic [W-1:0]  f_ln, f_ld, f_rn, f_rd;
  logic [W-1:0]  b_ln, b_ld, b_rn, b_rd;
  logic [QW-1:0] q_rdata;
  logic          q_avail, q_take;
  logic [RES_NUM_W-1:0] num_raw;

  rau_front #(.W(W)) u_front (
    .opcode_i  (opcode_i),
    .lhs_num_i (lhs_num_i),
    .lhs_den_i (lhs_den_i),
    .rhs_num_i (rhs_num_i),
    .rhs_den_i (rhs_den_i),
    .cls_o     (f_cls),
    .ln_o      (f_ln),
    .ld_o      (f_ld),
    .rn_o      (f_rn),
    .rd_o      (f_rd)
  );

  rau_queue #(.DW(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i),
    .wdata_i ({f_cls, f_ln, f_ld, f_rn, f_rd}),
    .full_o  (full_o),
    .rd_i    (q_take),
    .rdata_o (q_rdata),
    .avail_o (q_avail)
  );

  assign {b_cls, b_ln, b_ld, b_rn, b_rd} = q_rdata;

  rau_back #(.W(W)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (q_avail),
    .take_o     (q_take),
    .cls_i      (b_cls),
    .ln_i       (b_ln),
    .ld_i       (b_ld),
    .rn_i       (b_rn),
    .rd_i       (b_rd),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .res_num_o  (num_raw),
    .res_den_o  (res_den_o),
    .is_equal_o (is_equal_o),
    .status_o   (status_o)
  );

  assign res_num_o = signed'(num_raw);

endmodule

@@ hw/rtl/rau_checker.sv @@
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           pop_i,
  input logic                           empty_o,
  input logic [rau_pkg::RES_NUM_W-1:0]  res_num_o,
  input logic [rau_pkg::RES_DEN_W-1:0]  res_den_o,
  input logic                           is_equal_o,
  input logic                           status_o
);
  import rau_pkg::*;

  `include "rational_arith_unit_assert.svh"

  // a waiting result holds until taken
  `RAU_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(res_num_o) && $stable(res_den_o))
  // error results are 0/1 and never report equality
  `RAU_ASSERT_IMP(a_err_zero, clk_i, rst_ni, !empty_o && status_o, res_num_o == '0 && res_den_o == RES_DEN_W'(1) && !is_equal_o)
  // an equal compare carries 0/1 and no error
  `RAU_ASSERT_IMP(a_eq_zero, clk_i, rst_ni, !empty_o && is_equal_o, res_num_o == '0 && res_den_o == RES_DEN_W'(1) && !status_o)

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop_i      (pop_i),
  .empty_o    (empty_o),
  .res_num_o  (res_num_o),
  .res_den_o  (res_den_o),
  .is_equal_o (is_equal_o),
  .status_o   (status_o)
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rational_arith_unit. Directed corner requests and
// then random ones are pushed with random idle bursts; each popped result is
// checked field by field against an exact in-bench rational predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int W = 16;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam int N_RAND = 1300;
  localparam int CALM   = 150;  // no idling for the last requests

  typedef struct {
    logic [2:0]          opcode;
    logic signed [W-1:0] lhs_num;
    logic signed [W-1:0] lhs_den;
    logic signed [W-1:0] rhs_num;
    logic [W-2:0]        rhs_den;
  } rat_req_t;

  typedef struct {
    logic [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0] den;
    logic                 eq;
    logic                 st;
  } rat_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  logic [2:0] opcode_i = '0;
  logic signed [W-1:0] lhs_num_i = '0, lhs_den_i = '0, rhs_num_i = '0;
  logic [W-2:0] rhs_den_i = '0;
  logic full_o, empty_o, is_equal_o, status_o;
  logic signed [RES_NUM_W-1:0] res_num_o;
  logic [RES_DEN_W-1:0] res_den_o;

  rational_arith_unit #(.OPERAND_WIDTH(W)) uut (.*);

  rat_req_t pending_reqs[$];
  rat_res_t expected_res[$];
  rat_req_t cur_req;
  rat_res_t got_res, want_res;
  int n_total = 0, n_accepted = 0, n_errors = 0;
  int push_gap = 0, pop_gap = 0;
  bit go;

  initial forever #10 clk_i = ~clk_i;

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic rat_res_t pack_res(bit neg, longint unsigned mag,
                                        longint unsigned den, bit eq, bit st);
    rat_res_t r;
    longint unsigned n;
    n = neg ? (64'd0 - mag) : mag;
    r.num = n[RES_NUM_W-1:0];
    r.den = den[RES_DEN_W-1:0];
    r.eq = eq;
    r.st = st;
    return r;
  endfunction

  function automatic rat_res_t reduce_res(bit neg, longint unsigned mag,
                                          longint unsigned den);
    longint unsigned g;
    g = gcd64(mag, den);
    if (g == 0) g = 1;
    mag = mag / g;
    den = den / g;
    if (mag == 0) begin
      neg = 0;
      den = 1;
    end
    return pack_res(neg, mag, den, 0, 0);
  endfunction

  function automatic longint unsigned mag16(logic signed [W-1:0] v);
    longint s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic rat_res_t rational_result(rat_req_t q);
    bit ln_neg, rn_neg, bneg, neg;
    longint unsigned ln, ld, rn, rd, g, m1, m2, a, b, mag;
    ln = mag16(q.lhs_num);
    ld = mag16(q.lhs_den);
    rn = mag16(q.rhs_num);
    rd = q.rhs_den;
    rn_neg = q.rhs_num[W-1];
    if (q.opcode > OP_RED || ld == 0) return pack_res(0, 0, 1, 0, 1);
    // left operand is always normalized first
    ln_neg = q.lhs_num[W-1] ^ q.lhs_den[W-1];
    g = gcd64(ln, ld);
    ln = ln / g;
    ld = ld / g;
    if (ln == 0) ln_neg = 0;
    if (q.opcode == OP_RED) return reduce_res(ln_neg, ln, ld);
    if (rd == 0 || (q.opcode == OP_DIV && rn == 0)) return pack_res(0, 0, 1, 0, 1);
    if (rn == 0) rn_neg = 0;
    case (q.opcode)
      OP_ADD, OP_SUB: begin
        g = gcd64(ld, rd);
        m1 = rd / g;
        m2 = ld / g;
        a = ln * m1;
        b = rn * m2;
        bneg = (q.opcode == OP_SUB) ? !rn_neg : rn_neg;
        if (ln_neg == bneg) begin
          neg = ln_neg; mag = a + b;
        end else if (a >= b) begin
          neg = ln_neg; mag = a - b;
        end else begin
          neg = bneg; mag = b - a;
        end
        return reduce_res(neg, mag, ld * m1);
      end
      OP_MUL: return reduce_res(ln_neg ^ rn_neg, ln * rn, ld * rd);
      OP_DIV: return reduce_res(ln_neg ^ rn_neg, ln * rd, ld * rn);
      default: return pack_res(0, 0, 1, (ln_neg == rn_neg) && (ln * rd == ld * rn), 0);
    endcase
  endfunction

  function automatic logic signed [W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return W'(int'($urandom_range(0, 12)) - 6);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return W'(int'($urandom_range(0, 200)) - 100);
      default: return W'($urandom());
    endcase
  endfunction

  function automatic rat_req_t rand_req();
    rat_req_t q;
    q.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
               3'($urandom_range(OP_ADD, OP_RED));
    q.lhs_num = rand_val();
    q.rhs_num = rand_val();
    q.rhs_den = ($urandom_range(0, 29) == 0) ? '0 :
                ($urandom_range(0, 3) == 0) ? 15'($urandom_range(1, 12)) :
                15'($urandom_range(1, 32767));
    case ($urandom_range(0, 9))
      0:       q.lhs_den = '0;
      1, 2:    q.lhs_den = rand_val();
      default: q.lhs_den = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 12)) :
                           16'($urandom_range(1, 32767));
    endcase
    // same-valued operands so compare and subtract hit equality
    if ($urandom_range(0, 7) == 0) begin
      q.rhs_num = q.lhs_num;
      q.rhs_den = q.lhs_den[W-2:0];
    end
    return q;
  endfunction

  task automatic add_req(logic [2:0] op, int ln, int ld, int rn, int rd);
    rat_req_t q;
    q.opcode = op;
    q.lhs_num = W'(ln);
    q.lhs_den = W'(ld);
    q.rhs_num = W'(rn);
    q.rhs_den = (W-1)'(rd);
    pending_reqs.push_back(q);
  endtask

  initial begin
    add_req(OP_ADD, 1, 2, 1, 3);
    add_req(OP_SUB, 1, 2, 1, 2);
    add_req(OP_SUB, -32768, 1, 32767, 1);
    add_req(OP_ADD, 32767, 32767, -32768, 32767);
    add_req(OP_MUL, -32768, 1, -32768, 1);
    add_req(OP_MUL, 1, 32767, 1, 32767);
    add_req(OP_DIV, 3, 4, -5, 6);
    add_req(OP_DIV, 3, 4, 0, 6);                // divide by zero
    add_req(OP_DIV, -32768, 1, 1, 32767);
    add_req(OP_CMP, 2, 4, 1, 2);                // unreduced left, equal
    add_req(OP_CMP, 1, 2, -1, 2);
    add_req(OP_CMP, 0, 5, 0, 3);
    add_req(OP_RED, 6, -4, 0, 0);               // negative denominator
    add_req(OP_RED, -32768, -32768, 0, 0);
    add_req(OP_RED, 5, 0, 1, 1);                // zero left denominator
    add_req(OP_ADD, 1, 0, 1, 1);
    add_req(OP_ADD, 1, 2, 1, 0);                // zero right denominator
    add_req(OP_MUL, 2, 3, 4, 6);                // unreduced right
    add_req(OP_MUL, 0, 1, 7, 9);
    add_req(OP_BAD6, 1, 1, 1, 1);
    add_req(OP_BAD7, -1, -1, -1, 32767);
    for (int i = 0; i < N_RAND; i++) pending_reqs.push_back(rand_req());
    n_total = pending_reqs.size();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (n_accepted == n_total && expected_res.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) begin
        expected_res.push_back(rational_result(cur_req));
        n_accepted++;
      end
      if (!(push_i && full_o)) begin
        go = 0;
        if (push_gap > 0) push_gap--;
        else if (pending_reqs.size() > CALM && $urandom_range(0, 7) == 0)
          push_gap = $urandom_range(1, 6) - 1;
        else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          go = 1;
        end
        push_i <= go;
        opcode_i <= cur_req.opcode;
        lhs_num_i <= cur_req.lhs_num;
        lhs_den_i <= cur_req.lhs_den;
        rhs_num_i <= cur_req.rhs_num;
        rhs_den_i <= cur_req.rhs_den;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        got_res = '{res_num_o, res_den_o, is_equal_o, status_o};
        if (expected_res.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result num=%0d den=%0d", $time, res_num_o, res_den_o);
        end else begin
          want_res = expected_res.pop_front();
          if (got_res.num !== want_res.num) begin
            n_errors++;
            $display("%0t: res_num exp %0d got %0d", $time,
                     $signed(want_res.num), $signed(got_res.num));
          end
          if (got_res.den !== want_res.den) begin
            n_errors++;
            $display("%0t: res_den exp %0d got %0d", $time, want_res.den, got_res.den);
          end
          if (got_res.eq !== want_res.eq) begin
            n_errors++;
            $display("%0t: is_equal exp %0b got %0b", $time, want_res.eq, got_res.eq);
          end
          if (got_res.st !== want_res.st) begin
            n_errors++;
            $display("%0t: status exp %0b got %0b", $time, want_res.st, got_res.st);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop_i <= 1'b0;
      end else if (pending_reqs.size() > CALM && $urandom_range(0, 5) == 0) begin
        pop_gap = $urandom_range(1, 6) - 1;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

endmodule
